>>> src/assert_macros.svh
// Assertion macros used by the text writer datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle check, sampled on clk, off during reset
`define LCDW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication check, sampled on clk, off during reset
`define LCDW_ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

>>> src/lcdw_pkg.sv
// Package: types, constants and helper functions of the LCD text writer
`timescale 1ns / 1ps

package lcdw_pkg;

	localparam int LINE_COUNT = 4;
	localparam int DIGITS     = 10;
	localparam int BCD_W      = 4 * DIGITS;

	localparam logic [5:0] ROW_LEN_RST = 6'd20;

	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] ADDR_MASK    = 8'h7F;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CMD_HOME     = 8'h02;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_POINT     = 8'h2E;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	localparam logic [7:0] CYR_HIGH [64] = '{
		8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
		8'hA5, 8'hA6, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
		8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
		8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
		8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
		8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
		8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
		8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
	};

	typedef enum logic [2:0] {
		OP_PUT_XLAT = 3'd0,
		OP_PUT_RAW  = 3'd1,
		OP_NUMBER   = 3'd2,
		OP_MOVE     = 3'd3,
		OP_CLEAR    = 3'd4
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XLAT,
		ST_RAW,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_INT,
		ST_POINT,
		ST_FRAC,
		ST_SPACE,
		ST_MOVE,
		ST_CLR,
		ST_HOME
	} state_t;

	typedef enum logic [3:0] {
		SRC_XLAT,
		SRC_RAW,
		SRC_MINUS,
		SRC_DIGIT,
		SRC_POINT,
		SRC_SPACE,
		SRC_MOVE,
		SRC_CLEAR,
		SRC_HOME
	} src_t;

	typedef struct packed {
		logic take;
		logic conv;
		logic pos_init;
		logic pos_dec;
		logic emit;
		src_t src;
		logic is_data;
		logic final_word;
	} cmd_t;

	typedef struct packed {
		logic    req_valid;
		opcode_t opcode;
		logic    conv_done;
		logic    neg;
		logic    digit_zero;
		logic    pos_gt_dec;
		logic    pos_zero;
		logic    dec_zero;
		logic    frac_nz;
		logic    drop;
		logic    out_free;
	} sts_t;

	function automatic logic [7:0] xlat(input logic [7:0] c);
		logic [7:0] r;
		if (c < 8'hA0)
			r = c;
		else if (c == 8'hA8)
			r = 8'hA2;
		else if (c == 8'hB8)
			r = 8'hB5;
		else if (c < 8'hC0)
			r = 8'h20;
		else
			r = CYR_HIGH[c[5:0]];
		return r;
	endfunction

	function automatic logic [7:0] line_base(input logic [1:0] l);
		logic [7:0] r;
		case (l)
			2'd0: r = 8'd0;
			2'd1: r = 8'd64;
			2'd2: r = 8'd20;
			default: r = 8'd84;
		endcase
		return r;
	endfunction

	// one double-dabble step: add 3 to digits above 4, then shift in b
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd, input logic b);
		logic [BCD_W-1:0] adj;
		adj = bcd;
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd[4*i +: 4] > 4'd4)
				adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
		end
		return {adj[BCD_W-2:0], b};
	endfunction

endpackage

>>> src/lcdw_if.sv
// Interfaces: request and byte channels of the LCD text writer
`timescale 1ns / 1ps

interface lcdw_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [7:0]  char_code;
	logic signed [31:0] value;
	logic [1:0]  decimals;
	logic [1:0]  line_index;
	logic [5:0]  column;

	modport source (output valid, opcode, char_code, value, decimals, line_index, column,
		input ready);
	modport sink (input valid, opcode, char_code, value, decimals, line_index, column,
		output ready);
endinterface

interface lcdw_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source (output valid, out_byte, is_data, last, input ready);
	modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

>>> src/lcdw_ctrl.sv
// Controller: sequences the bytes of one request
`timescale 1ns / 1ps

module lcdw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  lcdw_pkg::sts_t  sts,
	output lcdw_pkg::cmd_t  cmd
);

	lcdw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lcdw_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.src = lcdw_pkg::SRC_XLAT;
		case (state_q)
			lcdw_pkg::ST_IDLE: begin
				cmd.take = 1'b1;
				if (sts.req_valid) begin
					case (sts.opcode)
						lcdw_pkg::OP_PUT_XLAT: state_d = lcdw_pkg::ST_XLAT;
						lcdw_pkg::OP_PUT_RAW:  state_d = lcdw_pkg::ST_RAW;
						lcdw_pkg::OP_NUMBER:   state_d = lcdw_pkg::ST_CONV;
						lcdw_pkg::OP_MOVE:     state_d = lcdw_pkg::ST_MOVE;
						lcdw_pkg::OP_CLEAR:    state_d = lcdw_pkg::ST_CLR;
						default:               state_d = lcdw_pkg::ST_IDLE;
					endcase
				end
			end
			lcdw_pkg::ST_XLAT, lcdw_pkg::ST_RAW: begin
				cmd.src = (state_q == lcdw_pkg::ST_XLAT) ? lcdw_pkg::SRC_XLAT : lcdw_pkg::SRC_RAW;
				cmd.is_data = 1'b1;
				cmd.final_word = 1'b1;
				if (sts.drop)
					state_d = lcdw_pkg::ST_IDLE;
				else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = lcdw_pkg::ST_IDLE;
				end
			end
			lcdw_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
				if (sts.conv_done) begin
					cmd.pos_init = 1'b1;
					state_d = sts.neg ? lcdw_pkg::ST_SIGN : lcdw_pkg::ST_SKIP;
				end
			end
			lcdw_pkg::ST_SIGN: begin
				cmd.src = lcdw_pkg::SRC_MINUS;
				cmd.is_data = 1'b1;
				if (sts.drop)
					state_d = lcdw_pkg::ST_IDLE;
				else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = lcdw_pkg::ST_SKIP;
				end
			end
			lcdw_pkg::ST_SKIP: begin
				if (sts.pos_gt_dec && sts.digit_zero)
					cmd.pos_dec = 1'b1;
				else
					state_d = lcdw_pkg::ST_INT;
			end
			lcdw_pkg::ST_INT: begin
				cmd.src = lcdw_pkg::SRC_DIGIT;
				cmd.is_data = 1'b1;
				cmd.final_word = sts.dec_zero && !sts.pos_gt_dec;
				if (sts.drop)
					state_d = lcdw_pkg::ST_IDLE;
				else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.pos_gt_dec)
						cmd.pos_dec = 1'b1;
					else if (sts.dec_zero)
						state_d = lcdw_pkg::ST_IDLE;
					else
						state_d = sts.frac_nz ? lcdw_pkg::ST_POINT : lcdw_pkg::ST_SPACE;
				end
			end
			lcdw_pkg::ST_POINT: begin
				cmd.src = lcdw_pkg::SRC_POINT;
				cmd.is_data = 1'b1;
				if (sts.drop)
					state_d = lcdw_pkg::ST_IDLE;
				else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.pos_dec = 1'b1;
					state_d = lcdw_pkg::ST_FRAC;
				end
			end
			lcdw_pkg::ST_FRAC, lcdw_pkg::ST_SPACE: begin
				cmd.src = (state_q == lcdw_pkg::ST_FRAC) ? lcdw_pkg::SRC_DIGIT : lcdw_pkg::SRC_SPACE;
				cmd.is_data = 1'b1;
				cmd.final_word = sts.pos_zero;
				if (sts.drop)
					state_d = lcdw_pkg::ST_IDLE;
				else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.pos_zero)
						state_d = lcdw_pkg::ST_IDLE;
					else
						cmd.pos_dec = 1'b1;
				end
			end
			lcdw_pkg::ST_MOVE: begin
				cmd.src = lcdw_pkg::SRC_MOVE;
				cmd.final_word = 1'b1;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = lcdw_pkg::ST_IDLE;
				end
			end
			lcdw_pkg::ST_CLR: begin
				cmd.src = lcdw_pkg::SRC_CLEAR;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = lcdw_pkg::ST_HOME;
				end
			end
			lcdw_pkg::ST_HOME: begin
				cmd.src = lcdw_pkg::SRC_HOME;
				cmd.final_word = 1'b1;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = lcdw_pkg::ST_IDLE;
				end
			end
			default: state_d = lcdw_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> src/lcdw_dp.sv
// Datapath: BCD conversion, cursor, byte select and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcdw_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_wr_en,
	input  logic [5:0]      cfg_wr_data,
	lcdw_req_if.sink        req,
	lcdw_rsp_if.source      rsp,
	input  lcdw_pkg::cmd_t  cmd,
	output lcdw_pkg::sts_t  sts
);

	logic [5:0]  row_len_q;
	logic [5:0]  cursor_q;
	logic [7:0]  char_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [1:0]  dec_q;
	logic [1:0]  line_q;
	logic [5:0]  col_q;
	logic [lcdw_pkg::BCD_W-1:0] bcd_q;
	logic [3:0]  cnt_q;
	logic [3:0]  pos_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_data_q;
	logic        out_last_q;

	logic        load;
	logic        out_free;
	logic [3:0]  digit;
	logic [1:0]  line_sat;
	logic [7:0]  adr;
	logic [7:0]  byte_sel;
	logic        last_sel;
	logic        frac_nz;

	assign load = cmd.take && req.valid;
	assign out_free = !out_valid_q || rsp.ready;
	assign digit = bcd_q[{pos_q, 2'b00} +: 4];
	assign line_sat = ({1'b0, line_q} >= 3'(lcdw_pkg::LINE_COUNT)) ?
		2'(lcdw_pkg::LINE_COUNT - 1) : line_q;
	assign adr = lcdw_pkg::line_base(line_sat) + {2'b00, col_q};

	always_comb begin
		case (dec_q)
			2'd1: frac_nz = (bcd_q[3:0] != 4'd0);
			2'd2: frac_nz = (bcd_q[7:0] != 8'd0);
			2'd3: frac_nz = (bcd_q[11:0] != 12'd0);
			default: frac_nz = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.src)
			lcdw_pkg::SRC_XLAT:  byte_sel = lcdw_pkg::xlat(char_q);
			lcdw_pkg::SRC_RAW:   byte_sel = char_q;
			lcdw_pkg::SRC_MINUS: byte_sel = lcdw_pkg::CH_MINUS;
			lcdw_pkg::SRC_DIGIT: byte_sel = lcdw_pkg::CH_ZERO | {4'b0000, digit};
			lcdw_pkg::SRC_POINT: byte_sel = lcdw_pkg::CH_POINT;
			lcdw_pkg::SRC_SPACE: byte_sel = lcdw_pkg::CH_SPACE;
			lcdw_pkg::SRC_MOVE:  byte_sel = lcdw_pkg::CMD_SET_ADDR | (adr & lcdw_pkg::ADDR_MASK);
			lcdw_pkg::SRC_CLEAR: byte_sel = lcdw_pkg::CMD_CLEAR;
			lcdw_pkg::SRC_HOME:  byte_sel = lcdw_pkg::CMD_HOME;
			default:             byte_sel = lcdw_pkg::CH_SPACE;
		endcase
	end

	// a data word that fills the line is the last one the request can place
	assign last_sel = cmd.final_word ||
		(cmd.is_data && ({1'b0, cursor_q} + 7'd1 >= {1'b0, row_len_q}));

	always_comb begin
		sts.req_valid  = req.valid;
		sts.opcode     = lcdw_pkg::opcode_t'(req.opcode);
		sts.conv_done  = (cnt_q == 4'd15);
		sts.neg        = neg_q;
		sts.digit_zero = (digit == 4'd0);
		sts.pos_gt_dec = (pos_q > {2'b00, dec_q});
		sts.pos_zero   = (pos_q == 4'd0);
		sts.dec_zero   = (dec_q == 2'd0);
		sts.frac_nz    = frac_nz;
		sts.drop       = (cursor_q >= row_len_q);
		sts.out_free   = out_free;
	end

	assign req.ready    = cmd.take;
	assign rsp.valid    = out_valid_q;
	assign rsp.out_byte = out_byte_q;
	assign rsp.is_data  = out_data_q;
	assign rsp.last     = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_len_q   <= lcdw_pkg::ROW_LEN_RST;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			pos_q       <= '0;
		end else begin
			if (cfg_wr_en)
				row_len_q <= cfg_wr_data;
			if (load)
				cnt_q <= '0;
			else if (cmd.conv)
				cnt_q <= cnt_q + 4'd1;
			if (cmd.pos_init)
				pos_q <= 4'(lcdw_pkg::DIGITS - 1);
			else if (cmd.pos_dec)
				pos_q <= pos_q - 4'd1;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				if (cmd.is_data)
					cursor_q <= cursor_q + 6'd1;
				else if (cmd.src == lcdw_pkg::SRC_MOVE)
					cursor_q <= col_q;
				else if (cmd.src == lcdw_pkg::SRC_HOME)
					cursor_q <= '0;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= req.char_code;
			neg_q  <= req.value[31];
			mag_q  <= req.value[31] ? 32'(-req.value) : 32'(req.value);
			dec_q  <= req.decimals;
			line_q <= req.line_index;
			col_q  <= req.column;
			bcd_q  <= '0;
		end else if (cmd.conv) begin
			bcd_q <= lcdw_pkg::dd_step(lcdw_pkg::dd_step(bcd_q, mag_q[31]), mag_q[30]);
			mag_q <= {mag_q[29:0], 2'b00};
		end
		if (cmd.emit) begin
			out_byte_q <= byte_sel;
			out_data_q <= cmd.is_data;
			out_last_q <= last_sel;
		end
	end

	`LCDW_ASSERT_IMPL(a_data_in_line, cmd.emit && cmd.is_data, cursor_q < row_len_q, "data past line end")
	`LCDW_ASSERT_IMPL(a_emit_free, cmd.emit, out_free, "word written over a held word")
	`LCDW_ASSERT(a_pos_range, pos_q < 4'(lcdw_pkg::DIGITS), "digit position out of range")

endmodule

>>> src/char_lcd_text_writer.sv
// Top level: character LCD text writer, controller plus datapath
`timescale 1ns / 1ps
// Takes text requests on req and produces controller words on rsp.
// Each rsp word is a byte with is_data (data vs command) and last (final word
// of the request). Opcodes: translated char, raw char, signed number with 0..3
// decimals, move to line/column, clear. Data words at or past the row length are
// dropped; a request whose words are all dropped gives none.
// cfg_wr_en/cfg_wr_data write the row length, which the user must do only while
// the block is idle; the block does not enforce this. req is taken only when
// the block is idle. Char, move: one word, sent once the output register is
// free. Clear: two words. Number: a binary to BCD conversion (two bits per
// cycle), a leading-zero skip over the zero digits, then one word per cycle
// while rsp does not stall, up to 12.
// The single output register holds a word until rsp.ready; while rsp stalls
// the sequencer waits and no word is lost.
// Reset: row length 20, cursor column 0, no word pending.

module char_lcd_text_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	lcdw_req_if.sink    req,
	lcdw_rsp_if.source  rsp
);

	lcdw_pkg::cmd_t cmd;
	lcdw_pkg::sts_t sts;

	lcdw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	lcdw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
